// File: rtl/core/kne_pkg.sv
package kne_pkg;

  // Build-time defaults
  localparam int KEY_MAX_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 16;
  localparam int SUM_W      = 48;
  localparam int LEN_W      = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;

  // Average: sum * 100 needs 55 bits, one quotient bit per divider step
  localparam int          DIV_W     = 55;
  localparam int          STEP_W    = 6;
  localparam logic [6:0]  AVG_SCALE = 7'd100;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYLEN  = 1'b1;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

  // Result kinds
  localparam logic KIND_NUMBER  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    PH_MATCH = 2'd0,
    PH_SKIP  = 2'd1,
    PH_NUM   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_WR   = 2'd2
  } bk_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] total_count;
    logic [SUM_W-1:0]   total_sum;
    logic [SUM_W-1:0]   average_x100;
    logic               last;
  } res_t;

  // Work queued from front to back
  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
    logic               last;
  } entry_t;

endpackage

// File: rtl/core/kne_front.sv
module kne_front #(
  parameter int KEY_MAX_BYTES = kne_pkg::KEY_MAX_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  kne_pkg::item_t                   item_i,
  output logic                             full_o,
  input  logic                             cfg_we_i,
  input  logic [kne_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kne_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             q_wr_o,
  output kne_pkg::entry_t                  q_wdata_o,
  input  logic                             q_full_i
);
  import kne_pkg::*;

  localparam int WIN_W  = 8 * KEY_MAX_BYTES;
  localparam int FILL_W = $clog2(KEY_MAX_BYTES + 1);
  localparam logic [LEN_W-1:0]  KEY_MAX_LEN = LEN_W'(KEY_MAX_BYTES);
  localparam logic [FILL_W-1:0] FILL_MAX    = FILL_W'(KEY_MAX_BYTES);

  logic [WIN_W-1:0]   keyword_q;
  logic [LEN_W-1:0]   key_len_q;
  logic [WIN_W-1:0]   win_q, win_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  phase_e             phase_q, phase_d;
  logic [VALUE_W-1:0] num_q, num_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               pend_q;
  entry_t             pend_entry_q;

  logic                   accept;
  logic [BYTE_W-1:0]      c;
  logic                   eot;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [LEN_W-1:0]       len_eff;
  logic [LEN_W-1:0]       shamt;
  logic [WIN_W+7:0]       win_cat;
  logic [WIN_W-1:0]       win_shift;
  logic [WIN_W-1:0]       tail;
  logic [FILL_W-1:0]      fill_inc;
  logic [KEY_MAX_BYTES-1:0] byte_ok;
  logic                   key_hit;
  logic [VALUE_W+3:0]     num_ext;
  logic                   do_push;
  logic                   emit_num;
  logic [VALUE_W-1:0]     fin_val;
  logic [SUM_W:0]         sum_ext;
  entry_t                 num_entry;
  entry_t                 sum_entry;

  assign full_o   = pend_q || q_full_i;
  assign accept   = push_i && !full_o;
  assign c        = item_i.text_byte;
  assign eot      = item_i.end_of_text;
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign digit    = 4'(c - CHAR_ZERO);

  // Clamp the configured length into 1..KEY_MAX_BYTES
  always_comb begin
    priority if (key_len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_len_q > KEY_MAX_LEN) begin
      len_eff = KEY_MAX_LEN;
    end else begin
      len_eff = key_len_q;
    end
  end

  // Shift the byte into the window and compare the newest bytes to the keyword
  assign win_cat   = {c, win_q};
  assign win_shift = win_cat[WIN_W+7:8];
  assign shamt     = KEY_MAX_LEN - len_eff;
  assign tail      = win_shift >> {shamt, 3'b000};
  assign fill_inc  = (fill_q == FILL_MAX) ? fill_q : fill_q + FILL_W'(1);

  always_comb begin
    for (int j = 0; j < KEY_MAX_BYTES; j++) begin
      byte_ok[j] = (LEN_W'(j) >= len_eff) || (tail[8*j +: 8] == keyword_q[8*j +: 8]);
    end
  end

  assign key_hit = (LEN_W'(fill_inc) >= len_eff) && (&byte_ok);

  // Extend the open number by one decimal digit
  assign num_ext = ({4'b0000, num_q} << 3) + ({4'b0000, num_q} << 1) + (VALUE_W + 4)'(digit);

  // Next state of the scanner for one accepted byte
  always_comb begin
    win_d    = win_q;
    fill_d   = fill_q;
    phase_d  = phase_q;
    num_d    = num_q;
    count_d  = count_q;
    sum_d    = sum_q;
    do_push  = 1'b0;
    emit_num = 1'b0;
    fin_val  = num_q;
    sum_ext  = '0;

    unique case (phase_q)
      PH_NUM: begin
        if (is_digit) begin
          num_d = (num_ext[VALUE_W+3:VALUE_W] != '0) ? '1 : num_ext[VALUE_W-1:0];
        end else begin
          emit_num = 1'b1;
          fin_val  = num_q;
          num_d    = '0;
          do_push  = 1'b1;
        end
      end
      PH_SKIP: begin
        if (is_digit) begin
          num_d   = VALUE_W'(digit);
          phase_d = PH_NUM;
        end else if (c == CHAR_NEWLINE) begin
          phase_d = PH_MATCH;
        end
      end
      default: begin
        do_push = 1'b1;
      end
    endcase

    if (do_push) begin
      phase_d = PH_MATCH;
      win_d   = win_shift;
      fill_d  = fill_inc;
      if (key_hit) begin
        win_d   = '0;
        fill_d  = '0;
        phase_d = PH_SKIP;
      end
    end

    // Close a number still open at end of text
    if (eot && (phase_d == PH_NUM)) begin
      emit_num = 1'b1;
      fin_val  = num_d;
    end

    if (emit_num) begin
      count_d = (count_q == '1) ? count_q : count_q + COUNT_W'(1);
      sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(fin_val);
      sum_d   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end

    num_entry.kind  = KIND_NUMBER;
    num_entry.value = fin_val;
    num_entry.count = count_d;
    num_entry.sum   = sum_d;
    num_entry.last  = !eot;

    sum_entry.kind  = KIND_SUMMARY;
    sum_entry.value = '0;
    sum_entry.count = count_d;
    sum_entry.sum   = sum_d;
    sum_entry.last  = 1'b1;

    // Start a new text after the summary
    if (eot) begin
      win_d   = '0;
      fill_d  = '0;
      phase_d = PH_MATCH;
      num_d   = '0;
      count_d = '0;
      sum_d   = '0;
    end
  end

  // Queue write: pending second result first, else this byte's first result
  always_comb begin
    q_wr_o    = 1'b0;
    q_wdata_o = num_entry;
    if (pend_q) begin
      q_wr_o    = !q_full_i;
      q_wdata_o = pend_entry_q;
    end else if (accept) begin
      if (emit_num) begin
        q_wr_o    = 1'b1;
        q_wdata_o = num_entry;
      end else if (eot) begin
        q_wr_o    = 1'b1;
        q_wdata_o = sum_entry;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyword_q <= '0;
      key_len_q <= LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEYWORD: keyword_q <= cfg_data_i[WIN_W-1:0];
        CFG_KEYLEN:  key_len_q <= cfg_data_i[LEN_W-1:0];
        default:     ;
      endcase
    end
  end

  // Scanner state, advance on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      phase_q <= PH_MATCH;
      num_q   <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else if (accept) begin
      win_q   <= win_d;
      fill_q  <= fill_d;
      phase_q <= phase_d;
      num_q   <= num_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  // Hold the summary when a byte produces two results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (pend_q) begin
      pend_q <= q_full_i;
    end else begin
      pend_q <= accept && emit_num && eot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!pend_q && accept) begin
      pend_entry_q <= sum_entry;
    end
  end

endmodule

// File: rtl/core/kne_fifo.sv
module kne_fifo #(
  parameter int DEPTH = kne_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  kne_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output kne_pkg::entry_t rdata_o,
  output logic            empty_o
);
  import kne_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/core/kne_back.sv
module kne_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kne_pkg::entry_t q_rdata_i,
  input  logic            q_empty_i,
  output logic            q_rd_o,
  output logic            empty_o,
  input  logic            pop_i,
  output kne_pkg::res_t   res_o
);
  import kne_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);
  localparam logic [DIV_W-1:0]  AVG_MAX   = DIV_W'({SUM_W{1'b1}});

  bk_state_e         state_q, state_d;
  entry_t            ent_q, ent_d;
  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              out_free;
  logic              out_load;
  res_t              out_new;
  logic [COUNT_W:0]  rem_sh;
  logic [COUNT_W:0]  rem_sub;
  logic              q_bit;

  assign empty_o  = !out_valid_q;
  assign res_o    = out_q;
  assign out_free = !out_valid_q || pop_i;

  // One restoring division step per cycle
  assign rem_sh  = {rem_q, dq_q[DIV_W-1]};
  assign q_bit   = rem_sh >= {1'b0, ent_q.count};
  assign rem_sub = rem_sh - {1'b0, ent_q.count};

  always_comb begin
    state_d  = state_q;
    ent_d    = ent_q;
    dq_d     = dq_q;
    rem_d    = rem_q;
    step_d   = step_q;
    q_rd_o   = 1'b0;
    out_load = 1'b0;

    out_new.kind         = q_rdata_i.kind;
    out_new.value        = q_rdata_i.value;
    out_new.total_count  = q_rdata_i.count;
    out_new.total_sum    = q_rdata_i.sum;
    out_new.average_x100 = '0;
    out_new.last         = q_rdata_i.last;

    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if ((q_rdata_i.kind == KIND_NUMBER) || (q_rdata_i.count == '0)) begin
            // Pass straight to the output register
            if (out_free) begin
              q_rd_o   = 1'b1;
              out_load = 1'b1;
            end
          end else begin
            // Start the average: sum * 100 / count
            q_rd_o  = 1'b1;
            ent_d   = q_rdata_i;
            dq_d    = DIV_W'(q_rdata_i.sum) * DIV_W'(AVG_SCALE);
            rem_d   = '0;
            step_d  = '0;
            state_d = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        dq_d   = {dq_q[DIV_W-2:0], q_bit};
        rem_d  = q_bit ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) begin
          state_d = BK_WR;
        end
      end
      BK_WR: begin
        out_new.kind         = ent_q.kind;
        out_new.value        = ent_q.value;
        out_new.total_count  = ent_q.count;
        out_new.total_sum    = ent_q.sum;
        out_new.average_x100 = (dq_q > AVG_MAX) ? '1 : dq_q[SUM_W-1:0];
        out_new.last         = ent_q.last;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Output register: load a new result or drop the one just taken
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d       = out_new;
      out_valid_d = 1'b1;
    end else if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    dq_q  <= dq_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

endmodule

// File: rtl/core/keyword_number_extractor_top.sv
// Keyword number extractor.
// Text enters one byte per transaction on the push/full side, with a flag on
// the final byte of each text. Each time the configured keyword appears, the
// decimal number after it is returned as a number result; the final byte
// also yields a summary with count, sum and average times 100.
// Results leave on the empty/pop side, oldest first; the head result is held
// on res_o while empty is low.
// Throughput: one byte per cycle while full is low. A final byte that also
// closes a number holds full high while its second result is queued.
// A number result is registered in the internal queue and then in the output register.
// A summary with a nonzero count first runs a bit-serial divider in the back
// end; the front keeps taking bytes until the internal queue fills.
// When pop is held low, the output register and the queue fill and full
// rises; nothing is dropped.
// Reset clears all scan state, sets the keyword to zero and its length to 1.
// Configuration writes take effect from the next byte.
module keyword_number_extractor_top #(
  parameter int KEY_MAX_BYTES = kne_pkg::KEY_MAX_BYTES_DEF,
  parameter int QUEUE_DEPTH   = kne_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  kne_pkg::item_t                 item_i,
  output logic                           empty,
  input  logic                           pop,
  output kne_pkg::res_t                  res_o,
  input  logic                           cfg_we_i,
  input  logic [kne_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kne_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import kne_pkg::*;

  logic   q_wr, q_full, q_rd, q_empty;
  entry_t q_wdata, q_rdata;

  kne_front #(
    .KEY_MAX_BYTES(KEY_MAX_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (item_i),
    .full_o    (full),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .q_wr_o    (q_wr),
    .q_wdata_o (q_wdata),
    .q_full_i  (q_full)
  );

  kne_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .rd_i   (q_rd),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  kne_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_rdata_i(q_rdata),
    .q_empty_i(q_empty),
    .q_rd_o   (q_rd),
    .empty_o  (empty),
    .pop_i    (pop),
    .res_o    (res_o)
  );

endmodule

// File: dv/tb_keyword_number_extractor_top.sv
`timescale 1ns / 100ps

module tb_keyword_number_extractor_top;
  import kne_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SAT_REPS      = 4;
  localparam logic [7:0]  CHAR_A        = "a";
  localparam logic [7:0]  CHAR_K        = "k";
  localparam logic [7:0]  CHAR_SEMI     = ";";

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  push       = 1'b0;
  logic                  full;
  item_t                 item_i     = '0;
  logic                  empty;
  logic                  pop        = 1'b0;
  res_t                  res_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = CFG_KEYWORD;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Scan state mirrored on the testbench side
  logic [CFG_DATA_W-1:0] kw_q     = '0;
  logic [LEN_W-1:0]      kw_len_q = 4'd1;
  logic [63:0]           window_q = '0;
  logic [3:0]            fill_q   = '0;
  phase_e                phase_q  = PH_MATCH;
  logic [VALUE_W-1:0]    number_q = '0;
  logic [COUNT_W-1:0]    count_q  = '0;
  logic [SUM_W-1:0]      sum_q    = '0;

  item_t       text_bytes[$];
  res_t        results_due[$];
  bit          idle_on      = 1'b1;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  int unsigned stall_cycles = 0;
  int unsigned error_count  = 0;

  keyword_number_extractor_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Clamp the keyword length into 1..max
  function automatic int unsigned key_bytes();
    if (kw_len_q == '0) return 1;
    if (kw_len_q > KEY_MAX_BYTES_DEF) return KEY_MAX_BYTES_DEF;
    return int'(kw_len_q);
  endfunction

  // Shift a byte into the window and look for the keyword at its tail
  function automatic void shift_window(input logic [7:0] c);
    int unsigned n;
    logic [63:0] tail;
    logic [63:0] kmask;
    n = key_bytes();
    window_q = {c, window_q[63:8]};
    if (fill_q < 4'd8) fill_q = fill_q + 4'd1;
    if (fill_q >= n) begin
      tail  = window_q >> (8 * (8 - n));
      kmask = (n == 8) ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
      if (tail == (kw_q & kmask)) begin
        window_q = '0;
        fill_q   = '0;
        phase_q  = PH_SKIP;
      end
    end
  endfunction

  // Close the open number and fold it into the running totals
  function automatic res_t close_number();
    res_t r;
    logic [SUM_W:0] wide;
    if (count_q != {COUNT_W{1'b1}}) count_q = count_q + 1'b1;
    wide  = {1'b0, sum_q} + {17'd0, number_q};
    sum_q = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
    r             = '0;
    r.kind        = KIND_NUMBER;
    r.value       = number_q;
    r.total_count = count_q;
    r.total_sum   = sum_q;
    number_q = '0;
    phase_q  = PH_MATCH;
    return r;
  endfunction

  // Advance the scan by one byte and queue the results it yields
  function automatic void scan_byte(input item_t it);
    res_t        out[$];
    res_t        r;
    logic [7:0]  c;
    logic [63:0] grown;
    logic [63:0] scaled;
    logic [63:0] avg;
    bit          is_num;
    c      = it.text_byte;
    is_num = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    case (phase_q)
      PH_NUM: begin
        if (is_num) begin
          grown    = {32'd0, number_q} * 64'd10 + {56'd0, c - CHAR_ZERO};
          number_q = (grown > 64'hFFFF_FFFF) ? {VALUE_W{1'b1}} : grown[31:0];
        end else begin
          out.push_back(close_number());
          shift_window(c);
        end
      end
      PH_SKIP: begin
        if (is_num) begin
          number_q = {24'd0, c - CHAR_ZERO};
          phase_q  = PH_NUM;
        end else if (c == CHAR_NEWLINE) begin
          phase_q = PH_MATCH;
        end
      end
      default: begin
        phase_q = PH_MATCH;
        shift_window(c);
      end
    endcase

    // End of text: flush an open number, then the summary, then start over
    if (it.end_of_text) begin
      if (phase_q == PH_NUM) out.push_back(close_number());
      avg = '0;
      if (count_q != '0) begin
        scaled = {16'd0, sum_q} * 64'd100;
        avg    = scaled / {48'd0, count_q};
        if (avg > {16'd0, {SUM_W{1'b1}}}) avg = {16'd0, {SUM_W{1'b1}}};
      end
      r              = '0;
      r.kind         = KIND_SUMMARY;
      r.total_count  = count_q;
      r.total_sum    = sum_q;
      r.average_x100 = avg[SUM_W-1:0];
      out.push_back(r);
      window_q = '0;
      fill_q   = '0;
      phase_q  = PH_MATCH;
      number_q = '0;
      count_q  = '0;
      sum_q    = '0;
    end

    foreach (out[i]) begin
      r      = out[i];
      r.last = (i == out.size() - 1);
      results_due.push_back(r);
    end
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic string field_diff(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want === got) return "";
    return $sformatf(" %s exp 0x%0h got 0x%0h", name, want, got);
  endfunction

  // Compare one result transaction with the oldest one due
  function automatic void check_result(input res_t got);
    res_t  want;
    string diffs;
    if (results_due.size() == 0) begin
      note_error($sformatf({"unexpected result: kind %0d value 0x%0h count %0d",
                            " sum 0x%0h avg 0x%0h last %0d"},
                           got.kind, got.value, got.total_count, got.total_sum,
                           got.average_x100, got.last));
      return;
    end
    want  = results_due.pop_front();
    diffs = {field_diff("kind", want.kind, got.kind),
             field_diff("value", want.value, got.value),
             field_diff("total_count", want.total_count, got.total_count),
             field_diff("total_sum", want.total_sum, got.total_sum),
             field_diff("average_x100", want.average_x100, got.average_x100),
             field_diff("last", want.last, got.last)};
    if (diffs != "") note_error({"result mismatch:", diffs});
  endfunction

  function automatic void put_byte(input logic [7:0] b, input logic eot);
    item_t it;
    it.text_byte   = b;
    it.end_of_text = eot;
    text_bytes.push_back(it);
  endfunction

  function automatic logic rare_eot();
    return ($urandom_range(0, 29) == 0);
  endfunction

  // Any byte that neither starts a number nor cancels a skip
  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_NEWLINE) begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  function automatic logic [63:0] letter_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = CHAR_A + 8'($urandom_range(0, 25));
    return w;
  endfunction

  // Mostly keyword-number sequences with random content, some broken ones and noise
  task automatic gen_texts(input int unsigned n_bytes);
    int unsigned base;
    int unsigned pick;
    int unsigned n;
    base = text_bytes.size();
    while (text_bytes.size() - base < n_bytes) begin
      pick = $urandom_range(0, 9);
      n    = key_bytes();
      if (pick <= 7) begin
        repeat ($urandom_range(0, 2)) put_byte(CHAR_A + 8'($urandom_range(0, 25)), rare_eot());
        for (int i = 0; i < n; i++) put_byte(kw_q[8*i +: 8], rare_eot());
      end
      if (pick <= 5) begin
        repeat ($urandom_range(0, 2)) put_byte(non_digit(), rare_eot());
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4))
          put_byte(CHAR_ZERO + 8'($urandom_range(0, 9)), rare_eot());
        case ($urandom_range(0, 3))
          0: put_byte(CHAR_NEWLINE, rare_eot());
          1: put_byte(($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00, rare_eot());
          2: put_byte(kw_q[7:0], rare_eot());
          default: put_byte(non_digit(), rare_eot());
        endcase
      end else if (pick == 6) begin
        // newline cuts the occurrence off before its digits
        put_byte(CHAR_NEWLINE, rare_eot());
        put_byte(CHAR_ZERO + 8'($urandom_range(0, 9)), rare_eot());
      end else if (pick == 7) begin
        // text ends while still skipping
        put_byte(non_digit(), 1'b1);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)), rare_eot());
      end else begin
        put_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_KEYWORD) kw_q = data;
    else if (idx == CFG_KEYLEN) kw_len_q = data[LEN_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every byte is taken and every result is back, then let the back end settle
  task automatic drain();
    while (text_bytes.size() != 0 || push || results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Byte driver: hold while full, idle in bursts, otherwise send the next byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push     <= 1'b0;
      send_gap <= 0;
    end else begin
      if (push && !full) scan_byte(item_i);
      if (push && full) begin
        // hold the transaction until it is taken
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        push     <= 1'b0;
      end else if (idle_on && text_bytes.size() != 0 && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 11);
        push     <= 1'b0;
      end else if (text_bytes.size() != 0) begin
        push   <= 1'b1;
        item_i <= text_bytes.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result monitor: check each popped transaction, stall pop in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (pop && !empty) check_result(res_o);
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        pop      <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 11);
        pop      <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: give up when neither side moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] kw_data;
    logic [63:0] len_data;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset keyword is a single NUL byte
    put_byte(8'h00, 1'b0);
    put_byte(CHAR_ZERO + 8'd4, 1'b0);
    put_byte(CHAR_ZERO + 8'd2, 1'b0);
    put_byte(8'hFF, 1'b0);
    // newline drops the occurrence
    put_byte(8'h00, 1'b0);
    put_byte(CHAR_NEWLINE, 1'b0);
    put_byte(CHAR_ZERO + 8'd7, 1'b0);
    // end of text while skipping, then an empty text
    put_byte(8'h00, 1'b1);
    put_byte(CHAR_A, 1'b1);
    // saturating number closed by end of text: number plus summary
    put_byte(8'h00, 1'b0);
    repeat (9) put_byte(CHAR_NINE, 1'b0);
    put_byte(CHAR_NINE, 1'b1);
    drain();

    // Random texts under a range of keyword settings
    for (int p = 0; p < 8; p++) begin
      len_data = {$urandom, $urandom};
      case (p)
        0: begin kw_data = letter_word();          len_data[3:0] = 4'd2; end
        1: begin kw_data = {64{1'b1}};             len_data[3:0] = 4'd8; end
        2: begin kw_data = {$urandom, $urandom};   len_data[3:0] = 4'd9; end
        3: begin kw_data = letter_word();          len_data[3:0] = 4'd0; end
        4: begin kw_data = {$urandom, $urandom};   len_data[3:0] = 4'd15; end
        5: begin kw_data = letter_word();          len_data[3:0] = 4'($urandom_range(1, 8)); end
        6: begin kw_data = '0;                     len_data[3:0] = 4'd1; end
        default: begin kw_data = letter_word();    len_data[3:0] = 4'($urandom_range(3, 7)); end
      endcase
      write_reg(CFG_KEYWORD, kw_data);
      write_reg(CFG_KEYLEN, len_data);
      @(negedge clk_i);
      idle_on <= ($urandom_range(0, 3) != 0);
      gen_texts(40);
      if ($urandom_range(0, 1) != 0) put_byte(8'($urandom_range(0, 255)), 1'b1);
      drain();
    end

    // Back-to-back maximal numbers with no idling on either side
    kw_data      = {$urandom, $urandom};
    kw_data[7:0] = CHAR_K;
    write_reg(CFG_KEYWORD, kw_data);
    write_reg(CFG_KEYLEN, {60'd0, 4'd1});
    @(negedge clk_i);
    idle_on <= 1'b0;
    for (int r = 0; r < SAT_REPS; r++) begin
      while (text_bytes.size() > 64) @(negedge clk_i);
      put_byte(CHAR_K, 1'b0);
      repeat (10) put_byte(CHAR_NINE, 1'b0);
    end
    put_byte(CHAR_SEMI, 1'b1);
    drain();

    if (results_due.size() != 0) note_error($sformatf("%0d results never arrived",
                                                      results_due.size()));
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/kne_pkg.sv
rtl/core/kne_front.sv
rtl/core/kne_fifo.sv
rtl/core/kne_back.sv
rtl/core/keyword_number_extractor_top.sv
dv/tb_keyword_number_extractor_top.sv
